/* sv/besa_pkg.sv */
// ----------------------------------------------------------------------------
// Branch edge sample aggregator package
// Shared constants, codes, types and helper functions of the edge table.
// ----------------------------------------------------------------------------
package besa_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
   localparam int PROBE_BITS  = SLOT_BITS + 1;

   localparam logic [63:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;
   localparam int HASH_SHL  = 6;
   localparam int HASH_SHR  = 2;
   localparam int HASH_FOLD = 29;

   localparam logic [11:0] MIN_PAYLOAD = 12'd68;
   localparam int BIT_RETURN = 34;
   localparam int BIT_TAKEN  = 35;
   localparam int BIT_MISP   = 36;
   localparam int BIT_BRANCH = 37;
   localparam int BIT_BADSRC = 38;

   localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;
   localparam logic [9:0]  LIMIT_RESET = 10'd716;

   localparam logic [2:0] STATUS_NEW     = 3'd0;
   localparam logic [2:0] STATUS_MERGED  = 3'd1;
   localparam logic [2:0] STATUS_NO_EDGE = 3'd2;
   localparam logic [2:0] STATUS_SHORT   = 3'd3;
   localparam logic [2:0] STATUS_DROPPED = 3'd4;
   localparam logic [2:0] STATUS_READ    = 3'd5;

   localparam int REQ_TDATA_BITS = 216;
   localparam int RSP_TDATA_BITS = 240;
   localparam int REQ_PLEN_LSB   = 0;
   localparam int REQ_SRC_LSB    = 12;
   localparam int REQ_DATA_LSB   = 76;
   localparam int REQ_TGT_LSB    = 140;
   localparam int REQ_IDX_LSB    = 204;

   typedef struct packed {
      logic        used;
      logic [63:0] source;
      logic [63:0] target;
      logic [31:0] samples;
      logic [31:0] mispredicts;
      logic [31:0] returns;
   } slot_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        slot_valid;
      logic [63:0] edge_from;
      logic [63:0] edge_to;
      logic [31:0] edge_count;
      logic [31:0] edge_mispredicts;
      logic [31:0] edge_returns;
      logic [9:0]  entries_used;
   } result_type;

   typedef struct packed {
      logic                 done;
      logic [SLOT_BITS-1:0] index;
   } hash_result_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] value, input logic inc);
      sat_inc = (value == SAT32) ? value : value + {31'd0, inc};
   endfunction

   function automatic result_type show_slot(input slot_type s, input logic [2:0] status,
                                            input logic [9:0] entries);
      result_type r;
      r.status           = status;
      r.slot_valid       = 1'b1;
      r.edge_from        = s.source;
      r.edge_to          = s.target;
      r.edge_count       = s.samples;
      r.edge_mispredicts = s.mispredicts;
      r.edge_returns     = s.returns;
      r.entries_used     = entries;
      show_slot = r;
   endfunction

endpackage

/* sv/branch_edge_sample_aggregator.sv */
// ----------------------------------------------------------------------------
// Branch edge sample aggregator
// Collects sampled taken branches into a linear-probing edge table.
// ----------------------------------------------------------------------------
// The req channel carries one command per transfer: tuser 0 adds a sample,
// tuser 1 reads the table slot named by slot_index. Every command gives
// exactly one transfer on the rsp channel, with the status code in tuser.
// The csr port sets the most distinct edges the table may hold.
// A rejected sample (too short or no edge) and a slot read skip the hash and
// the probe loop. The add time is set by the hash, which runs three partial
// products through one 32x32 multiplier and then mixes and folds the key, and
// by the probe loop, which reads one slot per cycle through the single read
// port of the table, so an add takes longer with every extra probe.
// Commands are taken one at a time; the next one is accepted once the
// previous result sits in the output register, even while rsp is stalled.
// After reset the block sweeps all 1024 slots to empty, one per cycle, and
// accepts no command until the sweep is done; csr writes are taken always.
// ----------------------------------------------------------------------------
module branch_edge_sample_aggregator
   import besa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [9:0]                csr_wr_data,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // payload_bytes, branch_source, op_data, branch_target, slot_index, zero fill
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // op
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // slot_valid, edge_from, edge_to, edge_count, edge_mispredicts, edge_returns,
   // entries_used, zero fill
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   // status
   output logic [2:0]                rsp_tuser
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HASH  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_PROBE = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [SLOT_BITS-1:0]  clr_idx_ff, clr_idx_in;
   logic [SLOT_BITS-1:0]  probe_idx_ff, probe_idx_in;
   logic [PROBE_BITS-1:0] probes_ff, probes_in;
   logic [9:0]            limit_ff;
   logic [9:0]            total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            res_ff, res_in;
   result_type            out_ff, out_in;

   logic [63:0]           from_ff;
   logic [63:0]           to_ff;
   logic                  misp_ff;
   logic                  ret_ff;
   logic                  read_ok_ff;

   slot_type              table_mem [TABLE_DEPTH];
   slot_type              rd_data_ff;
   logic [SLOT_BITS-1:0]  rd_addr;
   logic [SLOT_BITS-1:0]  wr_addr;
   slot_type              wr_data;
   logic                  wr_en;

   logic                  req_accept;
   logic                  hash_start;
   hash_result_type       hash_result;

   logic [11:0]           req_plen;
   logic [63:0]           req_source;
   logic [63:0]           req_data;
   logic [63:0]           req_target;
   logic [9:0]            req_index;
   logic                  req_is_edge;
   result_type            empty_res;

   assign req_plen   = req_tdata[REQ_PLEN_LSB +: 12];
   assign req_source = req_tdata[REQ_SRC_LSB +: 64];
   assign req_data   = req_tdata[REQ_DATA_LSB +: 64];
   assign req_target = req_tdata[REQ_TGT_LSB +: 64];
   assign req_index  = req_tdata[REQ_IDX_LSB +: 10];

   assign req_is_edge = req_data[BIT_BRANCH] && req_data[BIT_TAKEN] && !req_data[BIT_BADSRC];
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;

   always_comb begin
      empty_res              = '0;
      empty_res.entries_used = total_ff;
   end

   besa_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .start     (hash_start),
      .from_addr (req_source),
      .to_addr   (req_target),
      .result    (hash_result)
   );

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      probe_idx_in = probe_idx_ff;
      probes_in    = probes_ff;
      total_in     = total_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_addr      = probe_idx_ff;
      wr_en        = 1'b0;
      wr_addr      = probe_idx_ff;
      wr_data      = rd_data_ff;
      hash_start   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_data    = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == SLOT_BITS'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser) begin
                  rd_addr  = SLOT_BITS'(req_index);
                  state_in = ST_READ;
               end else if (req_plen < MIN_PAYLOAD) begin
                  res_in        = empty_res;
                  res_in.status = STATUS_SHORT;
                  state_in      = ST_DONE;
               end else if (!req_is_edge) begin
                  res_in        = empty_res;
                  res_in.status = STATUS_NO_EDGE;
                  state_in      = ST_DONE;
               end else begin
                  hash_start = 1'b1;
                  state_in   = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            if (hash_result.done) begin
               rd_addr      = hash_result.index;
               probe_idx_in = hash_result.index;
               probes_in    = PROBE_BITS'(1);
               state_in     = ST_PROBE;
            end
         end
         ST_READ: begin
            if (read_ok_ff && rd_data_ff.used) begin
               res_in = show_slot(rd_data_ff, STATUS_READ, total_ff);
            end else begin
               res_in        = empty_res;
               res_in.status = STATUS_READ;
            end
            state_in = ST_DONE;
         end
         ST_PROBE: begin
            if (!rd_data_ff.used) begin
               if (total_ff >= limit_ff) begin
                  res_in           = empty_res;
                  res_in.status    = STATUS_DROPPED;
                  res_in.edge_from = from_ff;
                  res_in.edge_to   = to_ff;
               end else begin
                  wr_en               = 1'b1;
                  wr_data.used        = 1'b1;
                  wr_data.source      = from_ff;
                  wr_data.target      = to_ff;
                  wr_data.samples     = 32'd1;
                  wr_data.mispredicts = {31'd0, misp_ff};
                  wr_data.returns     = {31'd0, ret_ff};
                  total_in            = total_ff + 10'd1;
                  res_in              = show_slot(wr_data, STATUS_NEW, total_in);
               end
               state_in = ST_DONE;
            end else if (rd_data_ff.source == from_ff && rd_data_ff.target == to_ff) begin
               wr_en               = 1'b1;
               wr_data.samples     = sat_inc(rd_data_ff.samples, 1'b1);
               wr_data.mispredicts = sat_inc(rd_data_ff.mispredicts, misp_ff);
               wr_data.returns     = sat_inc(rd_data_ff.returns, ret_ff);
               res_in              = show_slot(wr_data, STATUS_MERGED, total_ff);
               state_in            = ST_DONE;
            end else if (probes_ff == PROBE_BITS'(TABLE_DEPTH)) begin
               res_in           = empty_res;
               res_in.status    = STATUS_DROPPED;
               res_in.edge_from = from_ff;
               res_in.edge_to   = to_ff;
               state_in         = ST_DONE;
            end else begin
               probe_idx_in = probe_idx_ff + 1'b1;
               rd_addr      = probe_idx_in;
               probes_in    = probes_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         total_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      probe_idx_ff <= probe_idx_in;
      probes_ff    <= probes_in;
      res_ff       <= res_in;
      out_ff       <= out_in;
      if (req_accept) begin
         from_ff    <= req_source;
         to_ff      <= req_target;
         misp_ff    <= req_data[BIT_MISP];
         ret_ff     <= req_data[BIT_RETURN];
         read_ok_ff <= ({22'd0, req_index} < TABLE_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {5'd0, out_ff.entries_used, out_ff.edge_returns,
                        out_ff.edge_mispredicts, out_ff.edge_count, out_ff.edge_to,
                        out_ff.edge_from, out_ff.slot_valid};

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      (total_in != total_ff) |-> (total_in == total_ff + 10'd1) && (state_ff == ST_PROBE))
      else $error("entry count changed outside a new edge insert");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR) || (state_ff == ST_PROBE))
      else $error("table written outside the clear pass or probe loop");

   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STATUS_NEW || rsp_tuser == STATUS_MERGED)) |-> rsp_tdata[0])
      else $error("new or merged edge reported without a valid slot");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready && !rsp_tvalid)
      else $error("command channel active during the clear pass");

endmodule

/* sv/besa_hash.sv */
// ----------------------------------------------------------------------------
// Edge pair hash unit
// Multiplicative hash of a source and target pair over one shared 32x32
// multiplier, reduced to a table slot index.
// ----------------------------------------------------------------------------
module besa_hash
   import besa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [63:0]     from_addr,
   input  logic [63:0]     to_addr,
   output hash_result_type result
);

   localparam logic [2:0] STEP_IDLE   = 3'd0;
   localparam logic [2:0] STEP_MUL_LL = 3'd1;
   localparam logic [2:0] STEP_MUL_HL = 3'd2;
   localparam logic [2:0] STEP_MUL_LH = 3'd3;
   localparam logic [2:0] STEP_ACC    = 3'd4;
   localparam logic [2:0] STEP_MIX    = 3'd5;
   localparam logic [2:0] STEP_FOLD   = 3'd6;

   logic [2:0]           step_ff, step_in;
   logic                 done_ff;
   logic [63:0]          from_ff;
   logic [63:0]          to_sum_ff;
   logic [63:0]          prod_ff;
   logic [63:0]          key_ff;
   logic [63:0]          mix_ff;
   logic [SLOT_BITS-1:0] index_ff;
   logic [31:0]          mul_a;
   logic [31:0]          mul_b;
   logic [63:0]          mul_prod;
   logic [63:0]          mixed;

   assign mul_a    = (step_ff == STEP_MUL_HL) ? from_ff[63:32] : from_ff[31:0];
   assign mul_b    = (step_ff == STEP_MUL_LH) ? GOLDEN[63:32] : GOLDEN[31:0];
   assign mul_prod = {32'd0, mul_a} * {32'd0, mul_b};
   assign mixed    = key_ff ^ mix_ff;

   always_comb begin
      step_in = step_ff;
      if (start) begin
         step_in = STEP_MUL_LL;
      end else if (step_ff == STEP_FOLD) begin
         step_in = STEP_IDLE;
      end else if (step_ff != STEP_IDLE) begin
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= (step_ff == STEP_FOLD);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         from_ff   <= from_addr;
         to_sum_ff <= to_addr + GOLDEN;
      end
      case (step_ff)
         STEP_MUL_LL: begin
            prod_ff <= mul_prod;
         end
         STEP_MUL_HL: begin
            key_ff  <= prod_ff;
            prod_ff <= mul_prod;
         end
         STEP_MUL_LH: begin
            key_ff  <= key_ff + {prod_ff[31:0], 32'd0};
            prod_ff <= mul_prod;
         end
         STEP_ACC: begin
            key_ff <= key_ff + {prod_ff[31:0], 32'd0};
         end
         STEP_MIX: begin
            mix_ff <= to_sum_ff + (key_ff << HASH_SHL) + (key_ff >> HASH_SHR);
         end
         STEP_FOLD: begin
            index_ff <= mixed[SLOT_BITS-1:0] ^ mixed[HASH_FOLD +: SLOT_BITS];
         end
         default: begin
         end
      endcase
   end

   assign result.done  = done_ff;
   assign result.index = index_ff;

endmodule
